FILE: src/utf8sd_pkg.sv
package utf8sd_pkg;

    // Kinds of result beat.
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_END   = 2'd2
    } result_kind_t;

    localparam int CP_WIDTH      = 31;
    localparam int TOTAL_WIDTH   = 32;
    localparam int PENDING_WIDTH = 3;

    // Byte classification constants.
    localparam logic [7:0] LEAD_LOW       = 8'hC2;
    localparam logic [7:0] LEAD_HIGH      = 8'hFE;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [7:0] CONT_BITS      = 8'h3F;
    localparam logic [7:0] LEAD2_BITS     = 8'h1F;
    localparam logic [7:0] LEAD3_BITS     = 8'h0F;
    localparam logic [7:0] LEAD4_BITS     = 8'h07;
    localparam logic [7:0] LEAD5_BITS     = 8'h03;
    localparam logic [7:0] LEAD6_BITS     = 8'h01;

endpackage

FILE: src/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, legacy 1 to 6 byte forms.
// Input channel: in_valid / in_stall carry one text_byte per beat. A zero byte
// in lead position ends the text and gives an end beat holding the count, unless an error came before it.
// Output channel: out_valid / out_stall carry result_kind, code_point and
// char_total. A byte gives at most one result beat; continuation bytes that do
// not complete a character, and bytes discarded after an error, give none.
// A byte accepted sits in the input register and is decoded into the result
// register, whose beat is then offered on out_valid.
// Throughput: one byte per cycle while the receiver does not stall; the decode
// is a single pass of logic from the input register to the result register.
// When the receiver stalls, the result register holds its beat and the input
// register holds its byte; in_stall rises only while both are occupied and the
// result cannot move, so no beat is lost or repeated.
// Reset (rst_n low, asynchronous) empties both registers and clears the
// decoder state and the character count.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             result_kind,
    output logic [CP_WIDTH-1:0]    code_point,
    output logic [TOTAL_WIDTH-1:0] char_total
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Input register.
    logic                     in_full_reg;
    logic [7:0]               byte_reg;

    // Decoder state.
    logic [PENDING_WIDTH-1:0] pending_reg, pending_next;
    logic [CP_WIDTH-1:0]      partial_reg, partial_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     failed_reg, failed_next;

    // Result register.
    logic                     out_full_reg;
    result_kind_t             kind_reg, kind_next;
    logic [CP_WIDTH-1:0]      cp_reg, cp_next;
    logic [TOTAL_WIDTH-1:0]   total_reg;
    logic                     emit_next;

    logic                     advance;
    logic                     in_take;
    logic [CP_WIDTH-1:0]      shifted;
    logic [COUNT_WIDTH-1:0]   count_inc;
    logic [TOTAL_WIDTH-1:0]   total_next;

    // The input byte moves on when the result register is free or being taken.
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign shifted   = {partial_reg[CP_WIDTH-7:0], byte_reg[5:0] & CONT_BITS[5:0]};
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + COUNT_WIDTH'(1) : count_reg;

    // Decode one byte against the current state.
    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        failed_next  = failed_reg;
        emit_next    = 1'b0;
        kind_next    = KIND_CHAR;
        cp_next      = '0;

        priority if (failed_reg)
        begin
            if (byte_reg == 8'h00)
            begin
                pending_next = '0;
                partial_next = '0;
                count_next   = '0;
                failed_next  = 1'b0;
            end
        end
        else if (pending_reg != '0)
        begin
            priority if (byte_reg == 8'h00)
            begin
                // Text ended inside a sequence: error, then a fresh start.
                pending_next = '0;
                partial_next = '0;
                count_next   = '0;
                emit_next    = 1'b1;
                kind_next    = KIND_ERROR;
            end
            else if ((byte_reg & CONT_MASK) != CONT_TAG)
            begin
                pending_next = '0;
                partial_next = '0;
                failed_next  = 1'b1;
                emit_next    = 1'b1;
                kind_next    = KIND_ERROR;
            end
            else if (pending_reg == PENDING_WIDTH'(1))
            begin
                pending_next = '0;
                partial_next = '0;
                count_next   = count_inc;
                emit_next    = 1'b1;
                kind_next    = KIND_CHAR;
                cp_next      = shifted;
            end
            else
            begin
                pending_next = pending_reg - PENDING_WIDTH'(1);
                partial_next = shifted;
            end
        end
        else
        begin
            priority if (byte_reg == 8'h00)
            begin
                pending_next = '0;
                partial_next = '0;
                count_next   = '0;
                emit_next    = 1'b1;
                kind_next    = KIND_END;
            end
            else if (!byte_reg[7])
            begin
                count_next = count_inc;
                emit_next  = 1'b1;
                kind_next  = KIND_CHAR;
                cp_next    = CP_WIDTH'(byte_reg);
            end
            else if (byte_reg < LEAD_LOW || byte_reg >= LEAD_HIGH)
            begin
                failed_next = 1'b1;
                emit_next   = 1'b1;
                kind_next   = KIND_ERROR;
            end
            else if (byte_reg[7:5] == 3'b110)
            begin
                partial_next = CP_WIDTH'(byte_reg & LEAD2_BITS);
                pending_next = PENDING_WIDTH'(1);
            end
            else if (byte_reg[7:4] == 4'b1110)
            begin
                partial_next = CP_WIDTH'(byte_reg & LEAD3_BITS);
                pending_next = PENDING_WIDTH'(2);
            end
            else if (byte_reg[7:3] == 5'b11110)
            begin
                partial_next = CP_WIDTH'(byte_reg & LEAD4_BITS);
                pending_next = PENDING_WIDTH'(3);
            end
            else if (byte_reg[7:2] == 6'b111110)
            begin
                partial_next = CP_WIDTH'(byte_reg & LEAD5_BITS);
                pending_next = PENDING_WIDTH'(4);
            end
            else
            begin
                partial_next = CP_WIDTH'(byte_reg & LEAD6_BITS);
                pending_next = PENDING_WIDTH'(5);
            end
        end
    end

    // The total reported is the count after this byte, limited to 32 bits.
    // An end beat reports the count before it is cleared.
    generate
        if (COUNT_WIDTH > TOTAL_WIDTH)
        begin : g_wide_count
            logic [COUNT_WIDTH-1:0] shown;
            always_comb
            begin
                shown = (kind_next == KIND_END) ? count_reg : count_next;
                if (shown[COUNT_WIDTH-1:TOTAL_WIDTH] != '0)
                    total_next = {TOTAL_WIDTH{1'b1}};
                else
                    total_next = shown[TOTAL_WIDTH-1:0];
            end
        end
        else
        begin : g_narrow_count
            always_comb
            begin
                if (kind_next == KIND_END)
                    total_next = TOTAL_WIDTH'(count_reg);
                else
                    total_next = TOTAL_WIDTH'(count_next);
            end
        end
    endgenerate

    // Input register and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            pending_reg <= '0;
            partial_reg <= '0;
            count_reg   <= '0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;
            if (advance)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
                failed_reg  <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= text_byte;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (advance)
            out_full_reg <= emit_next;
        else if (!out_stall)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_next)
        begin
            kind_reg  <= kind_next;
            cp_reg    <= cp_next;
            total_reg <= total_next;
        end
    end

    assign out_valid   = out_full_reg;
    assign result_kind = kind_reg;
    assign code_point  = cp_reg;
    assign char_total  = total_reg;

endmodule
